// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/icf_pkg.sv =====
// ----------------------------------------------------------------------------
// Interpolated comb filter package
// Types, register indexes, the root table with its square root helper and a saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package icf_pkg;

    typedef logic signed [23:0] t_sample;
    typedef logic        [19:0] t_level;
    typedef logic        [31:0] t_root_tab [16];

    localparam logic [1:0] CFG_DELAY    = 2'd0;
    localparam logic [1:0] CFG_FB_GAIN  = 2'd1;
    localparam logic [1:0] CFG_FF_GAIN  = 2'd2;
    localparam logic [1:0] CFG_EXPONENT = 2'd3;

    localparam logic [16:0] GAIN_ONE = 17'd65536;

    function automatic logic [63:0] f_isqrt(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] bit_v;
        n     = n_in;
        res   = '0;
        bit_v = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (n >= res + bit_v) begin
                n   = n - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // Entry j holds 2^(-1/2^(j+1)) in Q0.32, each one the root of the last.
    function automatic t_root_tab f_root_tab();
        t_root_tab   tab;
        logic [63:0] c;
        c = 64'h8000_0000;
        for (int j = 0; j < 16; j++) begin
            c      = f_isqrt(c << 32);
            tab[j] = c[31:0];
        end
        return tab;
    endfunction

    localparam t_root_tab ROOT_TAB = f_root_tab();

    function automatic t_sample f_sat24(input logic signed [26:0] v);
        if (v > 27'sd8388607) begin
            return 24'sh7FFFFF;
        end else if (v < -27'sd8388608) begin
            return 24'sh800000;
        end
        return v[23:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/icf_req_if.sv =====
// ----------------------------------------------------------------------------
// Input request channel
// Valid/ready channel carrying one audio sample and its envelope level.
// ----------------------------------------------------------------------------
`default_nettype none

interface icf_req_if import icf_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample sample_in;
    t_level  envelope_level;

    modport source (output valid, output sample_in, output envelope_level, input ready);
    modport sink   (input valid, input sample_in, input envelope_level, output ready);
endinterface

`default_nettype wire

// ===== rtl/icf_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Output response channel
// Valid/ready channel carrying one filtered audio sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface icf_rsp_if import icf_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/interpolated_comb_filter_unit.sv =====
// ----------------------------------------------------------------------------
// Interpolated comb filter unit
// Feedback and feedforward comb filter with envelope-scaled coefficients.
// ----------------------------------------------------------------------------
// Each request on i_req carries a sample and an envelope level and yields one
// sample on o_rsp. The four registers are written over the i_cfg port; the
// user must write them only while the unit is idle, as the unit does not
// enforce it. One shared 33 by 33 multiplier under a sequencer does all the
// multiplications, so one request is worked on at a time and i_req.ready is
// high only while the sequencer is idle. The gain steps are skipped when the
// envelope gain is trivially one or zero; otherwise they take up to 15
// normalize shifts, 16 squarings for the logarithm and up to 16 multiplies
// for the power. The sequencer returns to idle once the result is loaded, so
// a new request is taken only after the last one is through. The delay line
// has one write port and one read port; the three taps are read in turn. A
// finished sample waits in the output register while the next request is
// taken; the sequencer stalls at its last step only if that register is
// still full. After reset the write index is zero and entries not yet
// written read as zero through a fill marker, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module interpolated_comb_filter_unit import icf_pkg::*; #(
    parameter int BUFFER_DEPTH = 4096
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    icf_req_if.sink     i_req,
    icf_rsp_if.source   o_rsp,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_idx,
    input  wire  [15:0] i_cfg_data
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int XW = AW + 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(BUFFER_DEPTH - 1);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_DMOD = 5'd1;
    localparam logic [4:0] S_RD_C = 5'd2;
    localparam logic [4:0] S_RD_B = 5'd3;
    localparam logic [4:0] S_RD_A = 5'd4;
    localparam logic [4:0] S_RD_E = 5'd5;
    localparam logic [4:0] S_NORM = 5'd6;
    localparam logic [4:0] S_SQ_M = 5'd7;
    localparam logic [4:0] S_SQ_U = 5'd8;
    localparam logic [4:0] S_NL_M = 5'd9;
    localparam logic [4:0] S_NL_U = 5'd10;
    localparam logic [4:0] S_PW_M = 5'd11;
    localparam logic [4:0] S_PW_U = 5'd12;
    localparam logic [4:0] S_GAIN = 5'd13;
    localparam logic [4:0] S_FB_K = 5'd14;
    localparam logic [4:0] S_FB_P = 5'd15;
    localparam logic [4:0] S_FB_T = 5'd16;
    localparam logic [4:0] S_FF_K = 5'd17;
    localparam logic [4:0] S_FF_P = 5'd18;
    localparam logic [4:0] S_FF_T = 5'd19;

    logic [4:0]          r_state;
    logic [11:0]         r_delay;
    logic signed [15:0]  r_fb;
    logic signed [15:0]  r_ff;
    logic [10:0]         r_e;

    t_sample             r_x;
    t_level              r_level;
    logic [11:0]         r_d;
    logic [AW-1:0]       r_ic;
    logic [AW-1:0]       r_wr_idx;
    logic                r_full;
    logic signed [25:0]  r_s4;
    logic [31:0]         r_m;
    logic [3:0]          r_ext;
    logic [15:0]         r_frac;
    logic [3:0]          r_cnt;
    logic [6:0]          r_ip;
    logic [15:0]         r_f;
    logic [31:0]         r_acc;
    logic [16:0]         r_g;
    t_sample             r_stored;
    logic signed [65:0]  r_prod;
    logic                r_out_valid;
    t_sample             r_out_data;

    t_sample             r_mem [BUFFER_DEPTH];
    t_sample             r_rdata;
    logic                r_rd_ok;

    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       ib;
    logic [AW-1:0]       ia;
    logic [XW-1:0]       w_x;
    logic [XW-1:0]       d_x;
    logic [AW-1:0]       ic_calc;
    t_sample             tap;
    logic signed [32:0]  mul_a;
    logic signed [32:0]  mul_b;
    logic [32:0]         sq_nm;
    logic [20:0]         nl;
    logic [63:0]         pw_rnd;
    logic [5:0]          g_sh;
    logic [33:0]         g_sum;
    logic [33:0]         g_q;
    logic [16:0]         g_val;
    logic signed [65:0]  p_rnd;
    logic signed [26:0]  term;
    t_sample             fb_sum;
    t_sample             ff_sum;
    logic                mem_we;
    logic                out_load;

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.sample_out = r_out_data;

    assign ib  = (r_ic == '0) ? LAST_IDX : r_ic - AW'(1);
    assign ia  = (r_ic == LAST_IDX) ? '0 : r_ic + AW'(1);
    assign w_x = {1'b0, r_wr_idx};
    assign d_x = XW'(r_d);
    assign ic_calc = (w_x >= d_x) ? AW'(w_x - d_x)
                                  : AW'(w_x + XW'(BUFFER_DEPTH) - d_x);
    assign tap = r_rd_ok ? r_rdata : '0;

    always_comb begin
        unique case (r_state)
            S_RD_B:  rd_addr = ib;
            S_RD_A:  rd_addr = ia;
            default: rd_addr = r_ic;
        endcase
    end

    assign nl = {5'(r_ext) + 5'd1, 16'h0000} - {5'b0, r_frac};

    always_comb begin
        unique case (r_state)
            S_SQ_M: begin
                mul_a = $signed({1'b0, r_m});
                mul_b = $signed({1'b0, r_m});
            end
            S_NL_M: begin
                mul_a = $signed({12'b0, nl});
                mul_b = $signed({22'b0, r_e});
            end
            S_PW_M: begin
                mul_a = $signed({1'b0, r_acc});
                mul_b = $signed({1'b0, ROOT_TAB[r_cnt]});
            end
            S_FB_K: begin
                mul_a = 33'(r_fb);
                mul_b = $signed({16'b0, r_g});
            end
            S_FF_K: begin
                mul_a = 33'(r_ff);
                mul_b = $signed({16'b0, r_g});
            end
            S_FB_P, S_FF_P: begin
                mul_a = $signed(r_prod[32:0]);
                mul_b = 33'(r_s4);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state != S_FF_T) begin
            r_prod <= mul_a * mul_b;
        end
    end

    assign sq_nm  = r_prod[63:31];
    assign pw_rnd = r_prod[63:0] + 64'h0000_0000_8000_0000;

    assign g_sh  = 6'(r_ip) + 6'd15;
    assign g_sum = {2'b00, r_acc} + (34'd1 << (g_sh - 6'd1));
    assign g_q   = g_sum >> g_sh;
    always_comb begin
        if (r_ip >= 7'd18) begin
            g_val = '0;
        end else if (g_q > 34'(GAIN_ONE)) begin
            g_val = GAIN_ONE;
        end else begin
            g_val = g_q[16:0];
        end
    end

    assign p_rnd  = r_prod + 66'sd4294967296;
    assign term   = 27'(p_rnd >>> 33);
    assign fb_sum = f_sat24(27'(r_x) + term);
    assign ff_sum = f_sat24(27'(r_stored) + term);

    assign mem_we   = (r_state == S_FB_T);
    assign out_load = (r_state == S_FF_T) && (!r_out_valid || o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wr_idx] <= fb_sum;
        end
        r_rdata <= r_mem[rd_addr];
        r_rd_ok <= r_full || (rd_addr < r_wr_idx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= 12'd109;
            r_fb    <= '0;
            r_ff    <= '0;
            r_e     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DELAY:    r_delay <= i_cfg_data[11:0];
                CFG_FB_GAIN:  r_fb    <= $signed(i_cfg_data);
                CFG_FF_GAIN:  r_ff    <= $signed(i_cfg_data);
                CFG_EXPONENT: r_e     <= i_cfg_data[10:0];
                default:      r_e     <= r_e;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= ff_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wr_idx <= '0;
            r_full   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_x     <= i_req.sample_in;
                        r_level <= i_req.envelope_level;
                        r_d     <= r_delay;
                        r_state <= S_DMOD;
                    end
                end
                S_DMOD: begin
                    if (32'(r_d) >= BUFFER_DEPTH) begin
                        r_d <= r_d - 12'(BUFFER_DEPTH);
                    end else begin
                        r_ic    <= ic_calc;
                        r_state <= S_RD_C;
                    end
                end
                S_RD_C: begin
                    r_state <= S_RD_B;
                end
                S_RD_B: begin
                    r_s4    <= 26'(tap) + 26'(tap);
                    r_state <= S_RD_A;
                end
                S_RD_A: begin
                    r_s4    <= r_s4 + 26'(tap);
                    r_state <= S_RD_E;
                end
                S_RD_E: begin
                    r_s4 <= r_s4 + 26'(tap);
                    if (r_e == '0) begin
                        r_g     <= GAIN_ONE;
                        r_state <= S_FB_K;
                    end else if (r_level == '0) begin
                        r_g     <= '0;
                        r_state <= S_FB_K;
                    end else if (r_level[19:16] != '0) begin
                        r_g     <= GAIN_ONE;
                        r_state <= S_FB_K;
                    end else begin
                        r_m     <= {r_level[15:0], 16'h0000};
                        r_ext   <= '0;
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (!r_m[31]) begin
                        r_m   <= r_m << 1;
                        r_ext <= r_ext + 4'd1;
                    end else begin
                        r_cnt   <= '0;
                        r_frac  <= '0;
                        r_state <= S_SQ_M;
                    end
                end
                S_SQ_M: begin
                    r_state <= S_SQ_U;
                end
                S_SQ_U: begin
                    r_m    <= sq_nm[32] ? sq_nm[32:1] : sq_nm[31:0];
                    r_frac <= {r_frac[14:0], sq_nm[32]};
                    r_cnt  <= r_cnt + 4'd1;
                    r_state <= (r_cnt == 4'd15) ? S_NL_M : S_SQ_M;
                end
                S_NL_M: begin
                    r_state <= S_NL_U;
                end
                S_NL_U: begin
                    r_ip    <= r_prod[30:24];
                    r_f     <= r_prod[23:8];
                    r_acc   <= 32'h8000_0000;
                    r_cnt   <= '0;
                    r_state <= S_PW_M;
                end
                S_PW_M: begin
                    if (r_f[15]) begin
                        r_state <= S_PW_U;
                    end else begin
                        r_f     <= r_f << 1;
                        r_cnt   <= r_cnt + 4'd1;
                        r_state <= (r_cnt == 4'd15) ? S_GAIN : S_PW_M;
                    end
                end
                S_PW_U: begin
                    r_acc   <= pw_rnd[63:32];
                    r_f     <= r_f << 1;
                    r_cnt   <= r_cnt + 4'd1;
                    r_state <= (r_cnt == 4'd15) ? S_GAIN : S_PW_M;
                end
                S_GAIN: begin
                    r_g     <= g_val;
                    r_state <= S_FB_K;
                end
                S_FB_K: begin
                    r_state <= S_FB_P;
                end
                S_FB_P: begin
                    r_state <= S_FB_T;
                end
                S_FB_T: begin
                    r_stored <= fb_sum;
                    r_wr_idx <= (r_wr_idx == LAST_IDX) ? '0 : r_wr_idx + AW'(1);
                    if (r_wr_idx == LAST_IDX) begin
                        r_full <= 1'b1;
                    end
                    r_state <= S_FF_K;
                end
                S_FF_K: begin
                    r_state <= S_FF_P;
                end
                S_FF_P: begin
                    r_state <= S_FF_T;
                end
                S_FF_T: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, i_req.valid && i_req.ready, r_state == S_DMOD, "accepted request did not start the sequencer")
    `ASSERT_SAME(a_gain_range, i_clk, i_rst_n, r_state == S_FB_K, r_g <= GAIN_ONE, "envelope gain above one")
    `ASSERT_NEXT(a_widx_hold, i_clk, i_rst_n, r_state != S_FB_T, $stable(r_wr_idx), "write index moved outside the store step")
    `ASSERT_SAME(a_tap_range, i_clk, i_rst_n, r_state == S_RD_C, 32'(r_ic) < BUFFER_DEPTH, "center tap beyond the delay line")

endmodule

`default_nettype wire

// ===== verif/interpolated_comb_filter_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Interpolated comb filter unit test
// Drives audio requests and register settings through the unit and compares
// every returned sample with a cycle-free model of the comb filter, including
// the envelope gain, the three-tap delay readout and both saturations.
// ----------------------------------------------------------------------------
`default_nettype none

module interpolated_comb_filter_unit_test import icf_pkg::*; ();

    localparam int WATCHDOG_LIMIT = 20000;

    class comb_response_predictor;
        logic signed [23:0] delay_line [4096];
        logic        [11:0] write_idx;
        logic        [11:0] delay_len;
        logic signed [15:0] fb_coef;
        logic signed [15:0] ff_coef;
        logic        [10:0] gain_exp;
        t_sample            expected_samples [$];
        int                 mismatches;

        function new();
            foreach (delay_line[i]) delay_line[i] = '0;
            write_idx  = '0;
            delay_len  = 12'd109;
            fb_coef    = '0;
            ff_coef    = '0;
            gain_exp   = '0;
            mismatches = 0;
        endfunction

        function void write_register(logic [1:0] idx, logic [15:0] data);
            case (idx)
                CFG_DELAY:    delay_len = data[11:0];
                CFG_FB_GAIN:  fb_coef   = data;
                CFG_FF_GAIN:  ff_coef   = data;
                CFG_EXPONENT: gain_exp  = data[10:0];
                default: ;
            endcase
        endfunction

        static function longint unsigned int_sqrt(longint unsigned n_in);
            longint unsigned n, res, bit_v;
            n     = n_in;
            res   = 0;
            bit_v = 64'd1 << 62;
            while (bit_v != 0) begin
                if (n >= res + bit_v) begin
                    n   = n - (res + bit_v);
                    res = (res >> 1) + bit_v;
                end else begin
                    res = res >> 1;
                end
                bit_v = bit_v >> 2;
            end
            return res;
        endfunction

        function longint unsigned envelope_gain(logic [19:0] level);
            longint unsigned m, frac, nl, t, ip, f, acc, c, s, g;
            int p;
            if (gain_exp == 0) return 65536;
            if (level == 0) return 0;
            if (level >= 20'd65536) return 65536;
            p = 0;
            for (int i = 0; i < 16; i++) begin
                if (level[i]) p = i;
            end
            m    = longint'(level) << (31 - p);
            frac = 0;
            for (int k = 0; k < 16; k++) begin
                m    = (m * m) >> 31;
                frac = frac << 1;
                if (m >= (64'd1 << 32)) begin
                    frac = frac | 1;
                    m    = m >> 1;
                end
            end
            nl  = longint'(16 - p) * 65536 - frac;
            t   = (nl * gain_exp) >> 8;
            ip  = t >> 16;
            f   = t & 64'hFFFF;
            acc = 64'd1 << 31;
            c   = 64'd1 << 31;
            for (int j = 1; j <= 16; j++) begin
                c = int_sqrt(c << 32);
                if ((f >> (16 - j)) & 1) acc = (acc * c + (64'd1 << 31)) >> 32;
            end
            s = 15 + ip;
            if (s >= 48) return 0;
            g = (acc + (64'd1 << (s - 1))) >> s;
            if (g > 65536) g = 65536;
            return g;
        endfunction

        static function longint scaled_term(longint s4, longint k, longint g);
            longint prod;
            prod = s4 * k * g;
            return (prod + (64'sd1 <<< 32)) >>> 33;
        endfunction

        static function logic signed [23:0] clip24(longint v);
            if (v > 64'sd8388607) return 24'sh7FFFFF;
            if (v < -64'sd8388608) return 24'sh800000;
            return v[23:0];
        endfunction

        function void note_request(t_sample s, t_level l);
            longint      g, s4;
            logic [11:0] ic, ib, ia;
            t_sample     stored;
            g      = envelope_gain(l);
            ic     = write_idx - delay_len;
            ib     = ic - 12'd1;
            ia     = ic + 12'd1;
            s4     = 2 * longint'(delay_line[ic]) + longint'(delay_line[ib])
                     + longint'(delay_line[ia]);
            stored = clip24(longint'(s) + scaled_term(s4, fb_coef, g));
            delay_line[write_idx] = stored;
            write_idx = write_idx + 12'd1;
            expected_samples.push_back(clip24(longint'(stored) + scaled_term(s4, ff_coef, g)));
        endfunction

        function void check_sample(t_sample actual);
            t_sample want;
            if (expected_samples.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected response: sample_out %0d", actual);
                return;
            end
            want = expected_samples.pop_front();
            if (actual !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch on sample_out: expected %0d, actual %0d", want, actual);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    icf_req_if req_ch ();
    icf_rsp_if rsp_ch ();

    interpolated_comb_filter_unit DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req_ch),
        .o_rsp     (rsp_ch),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    comb_response_predictor predictor = new();

    int send_idle_pct;
    int recv_stall_pct;
    int holdoff_cycles;
    int quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_idx             = '0;
        i_cfg_data            = '0;
        req_ch.valid          = 1'b0;
        req_ch.sample_in      = '0;
        req_ch.envelope_level = '0;
        rsp_ch.ready          = 1'b0;
        send_idle_pct         = 0;
        recv_stall_pct        = 0;
        holdoff_cycles        = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if (holdoff_cycles > 0) begin
            rsp_ch.ready   <= 1'b0;
            holdoff_cycles <= holdoff_cycles - 1;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) predictor.write_register(i_cfg_idx, i_cfg_data);
            if (req_ch.valid && req_ch.ready)
                predictor.note_request(req_ch.sample_in, req_ch.envelope_level);
            if (rsp_ch.valid && rsp_ch.ready) predictor.check_sample(rsp_ch.sample_out);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(int delay_v, int fb, int ff, int ex);
        write_reg(CFG_DELAY, {4'($urandom), 12'(delay_v)});
        write_reg(CFG_FB_GAIN, 16'(fb));
        write_reg(CFG_FF_GAIN, 16'(ff));
        write_reg(CFG_EXPONENT, {5'($urandom), 11'(ex)});
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_request(t_sample s, t_level l);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.sample_in      <= s;
        req_ch.envelope_level <= l;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (predictor.expected_samples.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic send_random(int count);
        t_sample s;
        t_level  l;
        repeat (count) begin
            case ($urandom_range(9))
                0:       l = '0;
                1:       l = 20'($urandom_range(65536, 1048575));
                2:       l = 20'($urandom);
                3:       l = 20'($urandom_range(1, 15));
                default: l = 20'($urandom_range(1, 65535));
            endcase
            case ($urandom_range(9))
                0:       s = 24'sh7FFFFF;
                1:       s = 24'sh800000;
                default: s = 24'($urandom);
            endcase
            send_request(s, l);
        end
    endtask

    initial begin
        t_sample edge_samples [5];
        t_level  edge_levels [7];
        int      delay_v, fb, ff, ex;

        edge_samples = '{24'sh7FFFFF, 24'sh800000, 24'sh000000, 24'shFFFFFF, 24'sh000001};
        edge_levels  = '{20'd0, 20'd1, 20'd32768, 20'd65535, 20'd65536, 20'hFFFFF, 20'h0AAAA};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < 10; i++) send_request(edge_samples[i % 5], edge_levels[i % 7]);
        drain();

        apply_settings(0, 32767, -32768, 2047);
        for (int i = 0; i < 14; i++) send_request(edge_samples[i % 5], edge_levels[i % 7]);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin delay_v = 1;    fb = -32768; ff = 32767;  ex = 1024; end
                1: begin delay_v = 4095; fb = 32767;  ff = -32768; ex = 256;  end
                2: begin delay_v = 0;    fb = 16384;  ff = 16384;  ex = 0;    end
                default: begin
                    delay_v = $urandom_range(0, 200);
                    fb      = $signed(16'($urandom));
                    ff      = $signed(16'($urandom));
                    ex      = $urandom_range(0, 9) == 0 ? $urandom_range(0, 2047)
                                                        : $urandom_range(0, 1024);
                end
            endcase
            apply_settings(delay_v, fb, ff, ex);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            if (ph == 4) holdoff_cycles = 400;
            send_random(200);
            drain();
        end

        repeat (120) @(posedge i_clk);
        if (predictor.mismatches == 0 && predictor.expected_samples.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== interpolated_comb_filter_unit.f =====
+incdir+rtl
rtl/icf_pkg.sv
rtl/icf_req_if.sv
rtl/icf_rsp_if.sv
rtl/interpolated_comb_filter_unit.sv
verif/interpolated_comb_filter_unit_test.sv
